/* rtl/maf_pkg.sv */
// ---------------------------------------------------------------------------
// maf_pkg
// Shared types, sizes and helpers of the moving average filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_W       = 7;
    localparam int POS_W       = $clog2(MAX_WINDOW);
    localparam int SUM_W       = SAMPLE_BITS + POS_W;
    localparam int CNT_W       = $clog2(SUM_W);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [WIN_W-1:0]       t_win;
    typedef logic        [POS_W-1:0]       t_pos;
    typedef logic        [CNT_W-1:0]       t_cnt;

    localparam t_win DEFAULT_WINDOW = t_win'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic start;
        t_sum dividend;
        t_win divisor;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_sample quotient;
    } t_div_rsp;

    function automatic t_win clamp_window(input t_win w);
        t_win r;
        if (w == '0) begin
            r = t_win'(1);
        end else if (w > t_win'(MAX_WINDOW)) begin
            r = t_win'(MAX_WINDOW);
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/maf_in_if.sv */
// ---------------------------------------------------------------------------
// maf_in_if
// Sample request channel: valid, ready and one signed sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface maf_in_if;
    logic             valid;
    logic             ready;
    maf_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/maf_out_if.sv */
// ---------------------------------------------------------------------------
// maf_out_if
// Result request channel: valid, ready and one signed average.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface maf_out_if;
    logic             valid;
    logic             ready;
    maf_pkg::t_sample average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

/* rtl/maf_div.sv */
// ---------------------------------------------------------------------------
// maf_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module maf_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  maf_pkg::t_div_req i_req,
    output maf_pkg::t_div_rsp o_rsp
);

    localparam int SUM_W = maf_pkg::SUM_W;
    localparam int WIN_W = maf_pkg::WIN_W;

    logic              r_busy;
    logic              r_done;
    maf_pkg::t_cnt     r_cnt;
    logic [WIN_W:0]    r_rem;
    logic [SUM_W-1:0]  r_quo;
    maf_pkg::t_win     r_div;
    logic              r_neg;

    logic [WIN_W:0]    trial;
    logic              fits;
    maf_pkg::t_sample  mag;

    assign trial = {r_rem[WIN_W-1:0], r_quo[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= maf_pkg::t_cnt'(SUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[SUM_W-1];
            r_quo <= i_req.dividend[SUM_W-1] ? (-i_req.dividend) : i_req.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign mag            = r_quo[maf_pkg::SAMPLE_BITS-1:0];
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (-mag) : mag;

endmodule

`default_nettype wire

/* rtl/moving_average_filter_top.sv */
// ---------------------------------------------------------------------------
// moving_average_filter_top
// Running-sum moving average over a ring of recent samples.
// ---------------------------------------------------------------------------
// Usage
//   i_in carries one signed sample per request, o_out one signed average per
//   request; both use valid/ready and move a request when both are high.
//   i_cfg_wr_en/i_cfg_wr_data write the window size (0 reads as 1, values
//   above the ring depth saturate); a write restarts the filter. Write only
//   while no sample is in flight.
//   One sample is worked on at a time: the next sample is accepted only once
//   the previous average has been loaded into the output register. The serial
//   divider works one quotient bit per cycle over the running sum width.
//   The ring lives in a single-port memory whose read at the write position
//   is registered ahead of the write; entries not yet written since the last
//   restart are taken as zero from the fill count, so there is no clearing
//   pass.
//   Reset restores a window of 16 and an empty ring. A stalled receiver holds
//   the result in the output register; the next sample is still accepted
//   and worked on, and waits after division until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    maf_in_if.sink        i_in,
    maf_out_if.source     o_out,
    input  wire           i_cfg_wr_en,
    input  maf_pkg::t_win i_cfg_wr_data
);

    maf_pkg::t_state  r_state, n_state;
    maf_pkg::t_win    r_window;
    maf_pkg::t_pos    r_pos;
    maf_pkg::t_win    r_fill;
    maf_pkg::t_sum    r_sum;
    maf_pkg::t_sample r_sample;
    maf_pkg::t_sample r_rd_data;
    maf_pkg::t_sample r_mem [maf_pkg::MAX_WINDOW];
    logic             r_out_valid;
    maf_pkg::t_sample r_out_data;

    maf_pkg::t_pos    n_pos;
    maf_pkg::t_win    n_fill;
    maf_pkg::t_sum    n_sum;
    maf_pkg::t_sample old_val;
    maf_pkg::t_win    pos_inc;
    maf_pkg::t_div_req div_req;
    maf_pkg::t_div_rsp div_rsp;
    logic             in_acc;
    logic             upd;
    logic             out_load;

    assign in_acc = i_in.valid && i_in.ready;
    assign upd    = (r_state == maf_pkg::ST_UPDATE);

    assign old_val = (r_fill == r_window) ? r_rd_data : '0;
    assign n_sum   = r_sum - maf_pkg::t_sum'(old_val) + maf_pkg::t_sum'(r_sample);
    assign pos_inc = maf_pkg::t_win'(r_pos) + maf_pkg::t_win'(1);
    assign n_pos   = (pos_inc >= r_window) ? '0 : maf_pkg::t_pos'(pos_inc);
    assign n_fill  = (r_fill < r_window) ? (r_fill + 1'b1) : r_fill;

    assign div_req.start    = upd;
    assign div_req.dividend = n_sum;
    assign div_req.divisor  = n_fill;

    maf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ring memory, read through a register at the write position ahead of the write
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_mem[r_pos] <= r_sample;
        end
        r_rd_data <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample;
        end
        if (out_load) begin
            r_out_data <= div_rsp.quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= maf_pkg::ST_IDLE;
            r_window    <= maf_pkg::DEFAULT_WINDOW;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window <= maf_pkg::clamp_window(i_cfg_wr_data);
                r_pos    <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
            end else if (upd) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            maf_pkg::ST_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_state = maf_pkg::ST_UPDATE;
                end
            end
            maf_pkg::ST_UPDATE: begin
                n_state = maf_pkg::ST_DIV;
            end
            maf_pkg::ST_DIV: begin
                if (div_rsp.done && (!r_out_valid || o_out.ready)) begin
                    out_load = 1'b1;
                    n_state  = maf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = maf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_out_data;

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_window)
        else $error("fill count beyond window");

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        maf_pkg::t_win'(r_pos) < r_window)
        else $error("write position beyond window");

    a_accept_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == maf_pkg::ST_UPDATE))
        else $error("accepted sample not processed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window != '0)
        else $error("zero window");

endmodule

`default_nettype wire
